/* hw/rtl/hki_pkg.sv */
package hki_pkg;

  localparam int unsigned TBits = 16;
  localparam int unsigned MaxLanes = 4;
  localparam int unsigned WeightW = 19;

  localparam logic [1:0] KindScalar = 2'd0;
  localparam logic [1:0] KindVec3 = 2'd1;
  localparam logic [1:0] KindQuat = 2'd2;
  localparam logic [1:0] KindQuatAlt = 2'd3;

  typedef struct packed {
    logic signed [WeightW-1:0] h1;
    logic signed [WeightW-1:0] h2;
    logic signed [WeightW-1:0] h3;
    logic signed [WeightW-1:0] h4;
  } weights_t;

  typedef struct packed {
    logic flip;
    logic quat;
  } lane_ctrl_t;

  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned s);
    logic signed [63:0] half;
    logic signed [63:0] r;
    half = 64'sd1 <<< (s - 1);
    if (v >= 0) begin
      r = (v + half) >>> s;
    end else begin
      r = -((-v + half) >>> s);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/hermite_key_interpolator.sv */
// Scalar and vec3 modes take the request through the weight, multiply and sum states to the result;
// quaternion mode adds a pass through the shared root and divide unit before the result.
// Throughput: one request at a time; the next request is taken in the cycle after the result
// is accepted, and no request is taken while a result waits to be accepted.
// The four lanes multiply in parallel; the normaliser works one bit per cycle.
// Reset clears the stored key, the key flag and sets the value kind to quaternion.
module hermite_key_interpolator #(
  parameter int unsigned LANES = 4,
  parameter int unsigned COMP_WIDTH = 24,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         restart_i,
  input  logic [16:0]                  param_t_i,
  input  logic signed [COMP_WIDTH-1:0] point_x_i,
  input  logic signed [COMP_WIDTH-1:0] point_y_i,
  input  logic signed [COMP_WIDTH-1:0] point_z_i,
  input  logic signed [COMP_WIDTH-1:0] point_w_i,
  input  logic signed [COMP_WIDTH-1:0] slope_x_i,
  input  logic signed [COMP_WIDTH-1:0] slope_y_i,
  input  logic signed [COMP_WIDTH-1:0] slope_z_i,
  input  logic signed [COMP_WIDTH-1:0] slope_w_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COMP_WIDTH-1:0] out_x_o,
  output logic signed [COMP_WIDTH-1:0] out_y_o,
  output logic signed [COMP_WIDTH-1:0] out_z_o,
  output logic signed [COMP_WIDTH-1:0] out_w_o
);

  localparam int unsigned ML = hki_pkg::MaxLanes;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWgt = 3'd1;
  localparam logic [2:0] StMul = 3'd2;
  localparam logic [2:0] StSum = 3'd3;
  localparam logic [2:0] StNorm = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [2:0] st_q;
  logic [1:0] kind_q;
  logic have_q;
  logic signed [COMP_WIDTH-1:0] pp_q [ML];
  logic signed [COMP_WIDTH-1:0] ps_q [ML];
  logic signed [COMP_WIDTH-1:0] p1_q [ML];
  logic signed [COMP_WIDTH-1:0] s1_q [ML];
  logic signed [COMP_WIDTH-1:0] p2_q [ML];
  logic signed [COMP_WIDTH-1:0] s2_q [ML];
  logic signed [COMP_WIDTH-1:0] pin [ML];
  logic signed [COMP_WIDTH-1:0] sin [ML];
  logic signed [COMP_WIDTH-1:0] lane_res [ML];
  logic signed [COMP_WIDTH-1:0] lane_sel [ML];
  logic signed [COMP_WIDTH-1:0] norm_res [ML];
  logic signed [COMP_WIDTH-1:0] out_q [ML];
  logic [16:0] t_q;
  logic [33:0] tt_q;
  hki_pkg::weights_t w_q;
  hki_pkg::lane_ctrl_t ctrl;
  logic [1:0] n;
  logic quat, flip_q, norm_done, accept;
  logic signed [2*COMP_WIDTH+2:0] dot;

  assign quat = kind_q[1];
  assign n = (kind_q == hki_pkg::KindScalar) ? 2'd0 :
             (kind_q == hki_pkg::KindVec3) ? 2'd2 : 2'd3;
  assign pin = '{point_x_i, point_y_i, point_z_i, point_w_i};
  assign sin = '{slope_x_i, slope_y_i, slope_z_i, slope_w_i};
  assign cfg_ready_o = (st_q == StIdle);
  assign in_ready_o = (st_q == StIdle);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = (st_q == StOut);
  assign out_x_o = out_q[0];
  assign out_y_o = out_q[1];
  assign out_z_o = out_q[2];
  assign out_w_o = out_q[3];
  assign ctrl = '{flip: flip_q, quat: quat};

  always_comb begin
    dot = '0;
    for (int i = 0; i < ML; i++) begin
      if (i <= int'(n) && i < LANES) begin
        dot = dot + (2*COMP_WIDTH+3)'(p1_q[i] * p2_q[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < ML; i++) begin
      lane_sel[i] = (i <= int'(n)) ? lane_res[i] : '0;
    end
  end

  for (genvar g = 0; g < ML; g++) begin : g_lane
    if (g < LANES) begin : g_on
      hki_lane #(.COMP_WIDTH(COMP_WIDTH)) u_lane (
        .clk_i (clk_i),
        .en_i  (st_q == StMul),
        .ctrl_i(ctrl),
        .w_i   (w_q),
        .p1_i  (p1_q[g]),
        .p2_i  (p2_q[g]),
        .s1_i  (s1_q[g]),
        .s2_i  (s2_q[g]),
        .res_o (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  hki_norm #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(st_q == StSum && quat),
    .n_i    ((LANES < 4) ? 2'(LANES - 1) : n),
    .v_i    (lane_sel),
    .done_o (norm_done),
    .res_o  (norm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      kind_q <= hki_pkg::KindQuat;
      have_q <= 1'b0;
      for (int i = 0; i < ML; i++) begin
        pp_q[i] <= '0;
        ps_q[i] <= '0;
      end
    end else begin
      unique case (st_q)
        StIdle: begin
          if (cfg_valid_i) kind_q <= cfg_data_i;
          if (accept) begin
            have_q <= 1'b1;
            pp_q <= pin;
            ps_q <= sin;
            if (have_q && !restart_i) st_q <= StWgt;
          end
        end
        StWgt: st_q <= StMul;
        StMul: st_q <= StSum;
        StSum: st_q <= quat ? StNorm : StOut;
        StNorm: if (norm_done) st_q <= StOut;
        StOut: if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [63:0] t1, t2, t3, one;
    if (accept) begin
      p1_q <= pp_q;
      s1_q <= ps_q;
      p2_q <= pin;
      s2_q <= sin;
      t_q <= (param_t_i > 17'd65536) ? 17'd65536 : param_t_i;
      tt_q <= 34'(((param_t_i > 17'd65536) ? 17'd65536 : param_t_i) *
                  ((param_t_i > 17'd65536) ? 17'd65536 : param_t_i));
    end
    if (st_q == StWgt) begin
      one = 64'sd1 <<< 48;
      t1 = 64'(t_q);
      t2 = 64'(tt_q) <<< 16;
      t3 = 64'(tt_q) * t1;
      w_q.h1 <= hki_pkg::WeightW'(hki_pkg::rnd_shr(2*t3 - 3*t2 + one, 32));
      w_q.h2 <= hki_pkg::WeightW'(hki_pkg::rnd_shr(-2*t3 + 3*t2, 32));
      w_q.h3 <= hki_pkg::WeightW'(hki_pkg::rnd_shr(t3 - 2*t2 + (t1 <<< 32), 32));
      w_q.h4 <= hki_pkg::WeightW'(hki_pkg::rnd_shr(t3 - t2, 32));
      flip_q <= dot < 0;
    end
    if (st_q == StSum) begin
      out_q <= lane_sel;
    end
    if (st_q == StNorm && norm_done) out_q <= norm_res;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o && !out_ready_i |=> out_valid_o);
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> have_q);
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> !in_ready_o);

endmodule

/* hw/rtl/hki_lane.sv */
module hki_lane #(
  parameter int unsigned COMP_WIDTH = 24
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  hki_pkg::lane_ctrl_t          ctrl_i,
  input  hki_pkg::weights_t            w_i,
  input  logic signed [COMP_WIDTH-1:0] p1_i,
  input  logic signed [COMP_WIDTH-1:0] p2_i,
  input  logic signed [COMP_WIDTH-1:0] s1_i,
  input  logic signed [COMP_WIDTH-1:0] s2_i,
  output logic signed [COMP_WIDTH-1:0] res_o
);

  localparam int unsigned PW = COMP_WIDTH + hki_pkg::WeightW;

  logic signed [PW-1:0] m1_q, m2_q, m3_q, m4_q;
  logic signed [COMP_WIDTH:0] q2;
  logic signed [63:0] sum, r;
  logic signed [63:0] hi, lo;

  assign q2 = (ctrl_i.quat && ctrl_i.flip) ? -$signed({p2_i[COMP_WIDTH-1], p2_i})
                                           : $signed({p2_i[COMP_WIDTH-1], p2_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= PW'(p1_i * w_i.h1);
      m2_q <= PW'(q2 * w_i.h2);
      m3_q <= PW'(s1_i * w_i.h3);
      m4_q <= PW'(s2_i * w_i.h4);
    end
  end

  always_comb begin
    hi = (64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    sum = 64'(m1_q) + 64'(m2_q) + 64'(m3_q) + 64'(m4_q);
    r = hki_pkg::rnd_shr(sum, hki_pkg::TBits);
    if (r > hi) begin
      res_o = COMP_WIDTH'(hi);
    end else if (r < lo) begin
      res_o = COMP_WIDTH'(lo);
    end else begin
      res_o = COMP_WIDTH'(r);
    end
  end

endmodule

/* hw/rtl/hki_norm.sv */
module hki_norm #(
  parameter int unsigned COMP_WIDTH = 24,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   n_i,
  input  logic signed [COMP_WIDTH-1:0] v_i [hki_pkg::MaxLanes],
  output logic                         done_o,
  output logic signed [COMP_WIDTH-1:0] res_o [hki_pkg::MaxLanes]
);

  localparam int unsigned NumW = COMP_WIDTH + FRAC_BITS + 1;
  localparam int unsigned SqW = 2 * COMP_WIDTH + 2;
  localparam int unsigned RootW = COMP_WIDTH + 1;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StSq = 3'd1;
  localparam logic [2:0] StRoot = 3'd2;
  localparam logic [2:0] StDiv = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] st_q, st_d;
  logic [1:0] lane_q;
  logic [SqW-1:0] rem_q;
  logic [SqW-1:0] root_q;
  logic [SqW-1:0] bit_q;
  logic [NumW-1:0] num_q;
  logic [NumW-1:0] quo_q;
  logic [NumW+RootW-1:0] dr_q;
  logic [6:0] cnt_q;
  logic signed [COMP_WIDTH-1:0] vals_q [hki_pkg::MaxLanes];
  logic [COMP_WIDTH:0] mag;
  logic [NumW+RootW-1:0] trial;

  assign mag = vals_q[lane_q][COMP_WIDTH-1] ? (COMP_WIDTH+1)'(-vals_q[lane_q])
                                              : (COMP_WIDTH+1)'(vals_q[lane_q]);
  assign trial = {dr_q[NumW+RootW-2:0], num_q[NumW-1]};
  assign done_o = (st_q == StDone);
  assign res_o = vals_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (start_i) st_d = StSq;
      StDone: st_d = StIdle;
      default: st_d = st_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else begin
      unique case (st_q)
        StIdle: st_q <= st_d;
        StSq: if (lane_q == n_i) st_q <= StRoot;
        StRoot: if (bit_q == '0) st_q <= (root_q == '0) ? StDone : StDiv;
        StDiv: if (cnt_q == 7'd0 && lane_q == n_i) st_q <= StDone;
        default: st_q <= st_d;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          vals_q <= v_i;
          lane_q <= '0;
          rem_q <= '0;
          bit_q <= SqW'(1) << (SqW - 2);
        end
      end
      StSq: begin
        rem_q <= rem_q + SqW'(mag * mag);
        if (lane_q == n_i) begin
          root_q <= '0;
          lane_q <= '0;
        end else begin
          lane_q <= lane_q + 2'd1;
        end
      end
      StRoot: begin
        if (bit_q != '0) begin
          if (rem_q >= root_q + bit_q) begin
            rem_q <= rem_q - (root_q + bit_q);
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          num_q <= (NumW'(mag) << FRAC_BITS) + NumW'(root_q >> 1);
          dr_q <= '0;
          quo_q <= '0;
          cnt_q <= 7'(NumW - 1);
        end
      end
      StDiv: begin
        if (cnt_q == 7'd0) begin
          logic [NumW-1:0] q;
          logic signed [COMP_WIDTH-1:0] s;
          q = {quo_q[NumW-2:0], (trial >= (NumW+RootW)'(root_q))};
          if (q > NumW'((64'd1 << (COMP_WIDTH - 1)) - 64'd1)) begin
            s = vals_q[lane_q][COMP_WIDTH-1] ? {1'b1, {(COMP_WIDTH-1){1'b0}}}
                                             : {1'b0, {(COMP_WIDTH-1){1'b1}}};
          end else begin
            s = vals_q[lane_q][COMP_WIDTH-1] ? -$signed(COMP_WIDTH'(q))
                                             : $signed(COMP_WIDTH'(q));
          end
          vals_q[lane_q] <= s;
          lane_q <= lane_q + 2'd1;
          num_q <= (NumW'(vals_q[lane_q + 2'd1][COMP_WIDTH-1]
                   ? (COMP_WIDTH+1)'(-vals_q[lane_q + 2'd1])
                   : (COMP_WIDTH+1)'(vals_q[lane_q + 2'd1])) << FRAC_BITS)
                   + NumW'(root_q >> 1);
          dr_q <= '0;
          quo_q <= '0;
          cnt_q <= 7'(NumW - 1);
        end else begin
          if (trial >= (NumW+RootW)'(root_q)) begin
            dr_q <= trial - (NumW+RootW)'(root_q);
            quo_q <= {quo_q[NumW-2:0], 1'b1};
          end else begin
            dr_q <= trial;
            quo_q <= {quo_q[NumW-2:0], 1'b0};
          end
          num_q <= num_q << 1;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      default: ;
    endcase
  end

endmodule
